/* rtl/sitda_pkg.sv */
// sitda_pkg: shared constants and types for the signed integer to decimal text block
// no dependencies

package sitda_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int STEP_BITS   = 4;
  localparam int CONV_BITS   = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int CONV_STEPS  = CONV_BITS / STEP_BITS;
  localparam int STEP_CNT_W  = $clog2(CONV_STEPS + 1);
  localparam int NUM_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int BCD_BITS    = NUM_DIGITS * 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } q_item_t;

  typedef struct packed {
    logic                 neg;
    logic [DIG_IDX_W-1:0] top;
    logic [BCD_BITS-1:0]  digits;
  } conv_res_t;

endpackage

/* rtl/sitda_if.sv */
// sitda_if: valid/ready channels for integer items in and character items out
// depends on sitda_pkg

interface sitda_in_if;
  import sitda_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/sitda_front.sv */
// sitda_front: accepts input items and splits them into sign and magnitude
// depends on sitda_pkg and sitda_if

module sitda_front (
  sitda_in_if.sink             in_ch,
  output sitda_pkg::q_item_t   push_item,
  output logic                 push_valid,
  input  logic                 push_ready
);
  import sitda_pkg::*;

  logic [VALUE_BITS-1:0] raw;

  assign raw              = $unsigned(in_ch.value);
  assign push_item.neg    = raw[VALUE_BITS-1];
  assign push_item.mag    = raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - raw) : raw;
  assign push_valid       = in_ch.valid;
  assign in_ch.ready      = push_ready;

endmodule

/* rtl/sitda_queue.sv */
// sitda_queue: short item queue between the front and the converter
// depends on sitda_pkg

module sitda_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  sitda_pkg::q_item_t  wr_item,
  input  logic                wr_valid,
  output logic                wr_ready,
  output sitda_pkg::q_item_t  rd_item,
  output logic                rd_valid,
  input  logic                rd_ready
);
  import sitda_pkg::*;

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* rtl/sitda_conv.sv */
// sitda_conv: binary magnitude to bcd digits, four shift-add-3 steps per cycle
// depends on sitda_pkg

module sitda_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sitda_pkg::q_item_t   q_item,
  input  logic                 q_valid,
  output logic                 q_ready,
  output sitda_pkg::conv_res_t res,
  output logic                 res_valid,
  input  logic                 res_ready
);
  import sitda_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  neg_r;
  logic [CONV_BITS-1:0]  bin_r, bin_w;
  logic [BCD_BITS-1:0]   bcd_r, bcd_w;
  logic                  done, load, step;
  logic [DIG_IDX_W-1:0]  top;

  assign done      = busy_r && (cnt_r == STEP_CNT_W'(CONV_STEPS));
  assign step      = busy_r && !done;
  assign load      = q_valid && (!busy_r || (done && res_ready));
  assign q_ready   = load;
  assign res_valid = done;

  always_comb begin
    bcd_w = bcd_r;
    bin_w = bin_r;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_w[d*4 +: 4] >= BCD_ADJ_MIN) begin
          bcd_w[d*4 +: 4] = bcd_w[d*4 +: 4] + BCD_ADJ;
        end
      end
      bcd_w = {bcd_w[BCD_BITS-2:0], bin_w[CONV_BITS-1]};
      bin_w = {bin_w[CONV_BITS-2:0], 1'b0};
    end
  end

  // most significant non-zero digit, zero gives digit 0
  always_comb begin
    top = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        top = DIG_IDX_W'(d);
      end
    end
  end

  assign res.neg    = neg_r;
  assign res.top    = top;
  assign res.digits = bcd_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (done && res_ready) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= q_item.neg;
      bin_r <= CONV_BITS'(q_item.mag);
      bcd_r <= '0;
    end else if (step) begin
      bin_r <= bin_w;
      bcd_r <= bcd_w;
    end
  end

endmodule

/* rtl/sitda_emit.sv */
// sitda_emit: sends the sign and digits of one converted item, one character per cycle
// while the output channel is ready; depends on sitda_pkg and sitda_if

module sitda_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sitda_pkg::conv_res_t res,
  input  logic                 res_valid,
  output logic                 res_ready,
  sitda_out_if.source          out_ch
);
  import sitda_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [BCD_BITS-1:0]  dig_r;
  logic                 ov_r, ov_nxt;
  logic [7:0]           char_r;
  logic                 last_r;
  logic                 load_out, fin, take;
  logic [3:0]           cur_dig;

  assign cur_dig   = dig_r[idx_r*4 +: 4];
  assign load_out  = busy_r && (!ov_r || out_ch.ready);
  assign fin       = load_out && !neg_r && (idx_r == '0);
  assign res_ready = !busy_r || fin;
  assign take      = res_valid && res_ready;

  assign out_ch.valid     = ov_r;
  assign out_ch.char_code = char_r;
  assign out_ch.last_char = last_r;

  always_comb begin
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r && !out_ch.ready;
    if (load_out) begin
      ov_nxt = 1'b1;
      if (neg_r) begin
        neg_nxt = 1'b0;
      end else if (idx_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      neg_nxt  = res.neg;
      idx_nxt  = res.top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      neg_r  <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      neg_r  <= neg_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dig_r <= res.digits;
    end
    if (load_out) begin
      char_r <= neg_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, cur_dig});
      last_r <= !neg_r && (idx_r == '0);
    end
  end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Signed integer to decimal text. Each input item is a 32-bit two's complement value; it
// leaves as a run of ASCII characters, most significant first: a '-' for a negative value,
// then the digits without leading zeros (zero gives a single '0'), with last_char set on
// the final character. The front takes one item per cycle while its two-item queue has
// room. The converter then turns the magnitude into decimal digits (four shift-add-3
// steps a cycle) and hands them over, and the output stage sends one character per cycle
// from a registered output while the output channel is ready. Conversion of one item
// overlaps the sending of the one before; an item gives 1 to 11 characters.
// depends on sitda_pkg, sitda_if, sitda_front, sitda_queue, sitda_conv, sitda_emit

module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  sitda_in_if.sink    in_ch,
  sitda_out_if.source out_ch
);
  import sitda_pkg::*;

  q_item_t   push_item, q_item;
  logic      push_valid, push_ready;
  logic      q_valid, q_ready;
  conv_res_t res;
  logic      res_valid, res_ready;

  sitda_front u_front (
    .in_ch      (in_ch),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  sitda_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_item  (push_item),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  sitda_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  sitda_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule
